/* hw/rtl/adsr_pkg.sv */
// ----------------------------------------------------------------------------
// ADSR envelope level package
// Word types, register indexes and default sizes shared by the envelope block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adsr_pkg;

   localparam int IN_BITS      = 32;
   localparam int TICK_BITS    = 24;
   localparam int LVL_BITS     = 16;
   localparam int CSR_IDX_BITS = 3;

   localparam int TIME_BITS_DEF       = 32;
   localparam int LEVEL_FRAC_BITS_DEF = 15;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ATTACK  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DECAY   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RELEASE = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PEAK    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD    = 3'd4;

   localparam logic [TICK_BITS-1:0] ATTACK_RST  = 24'd441;
   localparam logic [TICK_BITS-1:0] DECAY_RST   = 24'd44100;
   localparam logic [TICK_BITS-1:0] RELEASE_RST = 24'd44100;
   localparam logic [LVL_BITS-1:0]  PEAK_RST    = 16'd32768;
   localparam logic [LVL_BITS-1:0]  HOLD_RST    = 16'd0;

   typedef struct packed {
      logic [IN_BITS-1:0] now_tick;
      logic [IN_BITS-1:0] press_tick;
      logic [IN_BITS-1:0] lift_tick;
   } req_type;

   typedef struct packed {
      logic [LVL_BITS-1:0] level;
      logic                silent;
   } rsp_type;

endpackage

/* hw/rtl/adsr_div.sv */
// ----------------------------------------------------------------------------
// ADSR pipelined divider
// Restoring divider, one quotient bit per stage, with a side word carried along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsr_div #(
   parameter int QW = 16,
   parameter int DW = 24,
   parameter int SW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [QW+DW-1:0] in_num,
   input  logic [DW-1:0]    in_den,
   input  logic [SW-1:0]    in_side,
   output logic             out_valid,
   output logic [QW-1:0]    out_quot,
   output logic [SW-1:0]    out_side
);

   localparam int NW = QW + DW;

   logic [QW-1:0] valid_ff;
   logic [NW-1:0] rem_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] quot_ff [QW];
   logic [SW-1:0] side_ff [QW];

   logic [NW-1:0] src_rem  [QW];
   logic [DW-1:0] src_den  [QW];
   logic [QW-1:0] src_quot [QW];
   logic [SW-1:0] src_side [QW];
   logic [NW-1:0] shd      [QW];
   logic [NW-1:0] rem_in   [QW];
   logic [QW-1:0] quot_in  [QW];

   always_comb begin
      for (int s = 0; s < QW; s++) begin
         if (s == 0) begin
            src_rem[s]  = in_num;
            src_den[s]  = in_den;
            src_quot[s] = '0;
            src_side[s] = in_side;
         end else begin
            src_rem[s]  = rem_ff[s-1];
            src_den[s]  = den_ff[s-1];
            src_quot[s] = quot_ff[s-1];
            src_side[s] = side_ff[s-1];
         end
         shd[s] = NW'(src_den[s]) << (QW - 1 - s);
         if (src_rem[s] >= shd[s]) begin
            rem_in[s]  = src_rem[s] - shd[s];
            quot_in[s] = src_quot[s] | (QW'(1) << (QW - 1 - s));
         end else begin
            rem_in[s]  = src_rem[s];
            quot_in[s] = src_quot[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[QW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < QW; s++) begin
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= src_den[s];
            quot_ff[s] <= quot_in[s];
            side_ff[s] <= src_side[s];
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

/* hw/rtl/adsr_envelope_level.sv */
// ----------------------------------------------------------------------------
// ADSR envelope level
// Gives the attack, decay, sustain and release level of a note at a given tick.
// ----------------------------------------------------------------------------
// Request words carry the current tick and the note's press and lift ticks;
// each request word gives one response word with the level and a silent flag.
// The register port never stalls; write ramp lengths and levels only while
// no request is in flight, as the block itself does not enforce this.
// Throughput is one word per cycle while the receiver takes responses. Two
// dividers, each retiring one quotient bit per stage, compute the level:
// one for the attack or decay ramp, one for release.
// The whole pipeline advances when the response register is empty or taken,
// so a stalled receiver holds every stage in place and nothing is lost.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsr_envelope_level #(
   parameter int TIME_BITS       = adsr_pkg::TIME_BITS_DEF,
   parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  adsr_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output adsr_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [adsr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [adsr_pkg::TICK_BITS-1:0]    csr_data
);

   import adsr_pkg::*;

   localparam int TW   = TIME_BITS;
   localparam int LW   = LEVEL_FRAC_BITS + 1;
   localparam int KB   = TICK_BITS;
   localparam int NW   = LW + KB;
   localparam int CW   = (TW > KB + 1) ? TW : KB + 1;
   localparam int DXW  = (TW > KB) ? TW : KB;
   localparam int XW   = (TW > IN_BITS) ? TW : IN_BITS;
   localparam int OW   = (LW > LVL_BITS) ? LW : LVL_BITS;
   localparam int EPS  = ((1 << LEVEL_FRAC_BITS) + 99999) / 100000;
   localparam int SW1  = 2 + LW + TW;
   localparam int SW2  = 2 + LW;
   localparam logic [LW-1:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

   logic en;

   // registers
   logic [KB-1:0]       att_ff, dec_ff, rel_ff;
   logic [LVL_BITS-1:0] peak_ff, hold_ff;
   logic [LW-1:0]       pk, hd;
   logic [OW-1:0]       pk_x, hd_x;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         att_ff  <= ATTACK_RST;
         dec_ff  <= DECAY_RST;
         rel_ff  <= RELEASE_RST;
         peak_ff <= PEAK_RST;
         hold_ff <= HOLD_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ATTACK:  att_ff  <= csr_data;
            CSR_DECAY:   dec_ff  <= csr_data;
            CSR_RELEASE: rel_ff  <= csr_data;
            CSR_PEAK:    peak_ff <= csr_data[LVL_BITS-1:0];
            CSR_HOLD:    hold_ff <= csr_data[LVL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pk_x = OW'(peak_ff);
      hd_x = OW'(hold_ff);
      pk   = (pk_x > OW'(FULL)) ? FULL : pk_x[LW-1:0];
      hd   = (hd_x > OW'(FULL)) ? FULL : hd_x[LW-1:0];
   end

   // capture
   logic          a_valid_ff;
   logic [TW-1:0] a_now_ff, a_press_ff, a_lift_ff;
   logic [XW-1:0] now_x, press_x, lift_x;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_comb begin
      now_x   = XW'(req_data.now_tick);
      press_x = XW'(req_data.press_tick);
      lift_x  = XW'(req_data.lift_tick);
   end

   // lifetime and time since lift
   logic          b_valid_ff, b_held_ff, b_held_in;
   logic [TW-1:0] b_life_ff, b_life_in, b_dead_ff, b_dead_in;

   always_comb begin
      b_held_in = a_press_ff > a_lift_ff;
      if (b_held_in) begin
         b_life_in = (a_now_ff >= a_press_ff) ? a_now_ff - a_press_ff : '0;
      end else begin
         b_life_in = a_lift_ff - a_press_ff;
      end
      b_dead_in = (a_now_ff >= a_lift_ff) ? a_now_ff - a_lift_ff : '0;
   end

   // ramp select and multiplier operands
   logic          c_valid_ff, c_held_ff, c_sub_ff, c_sub_in;
   logic [LW-1:0] c_ma_ff, c_ma_in, c_base_ff, c_base_in;
   logic [KB-1:0] c_mb_ff, c_mb_in, c_den_ff, c_den_in;
   logic [TW-1:0] c_dead_ff;
   logic [CW-1:0] life_c, att_c, ad_c, since_c;

   always_comb begin
      life_c  = CW'(b_life_ff);
      att_c   = CW'(att_ff);
      ad_c    = CW'(att_ff) + CW'(dec_ff);
      since_c = life_c - att_c;
      if (att_ff != '0 && life_c <= att_c) begin
         c_ma_in   = pk;
         c_mb_in   = life_c[KB-1:0];
         c_den_in  = att_ff;
         c_base_in = '0;
         c_sub_in  = 1'b0;
      end else if (dec_ff != '0 && life_c <= ad_c) begin
         c_sub_in  = pk >= hd;
         c_ma_in   = c_sub_in ? pk - hd : hd - pk;
         c_mb_in   = since_c[KB-1:0];
         c_den_in  = dec_ff;
         c_base_in = pk;
      end else begin
         c_ma_in   = '0;
         c_mb_in   = '0;
         c_den_in  = KB'(1);
         c_base_in = hd;
         c_sub_in  = 1'b0;
      end
   end

   // multiply into first divider
   logic           d_valid_ff;
   logic [NW-1:0]  d_num_ff;
   logic [KB-1:0]  d_den_ff;
   logic [SW1-1:0] d_side_ff;

   logic           q1_valid;
   logic [LW-1:0]  q1_quot;
   logic [SW1-1:0] q1_side;

   adsr_div #(.QW(LW), .DW(KB), .SW(SW1)) u_div_ramp (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (d_valid_ff),
      .in_num    (d_num_ff),
      .in_den    (d_den_ff),
      .in_side   (d_side_ff),
      .out_valid (q1_valid),
      .out_quot  (q1_quot),
      .out_side  (q1_side)
   );

   // level at lift and release operands
   logic           q1_held, q1_sub;
   logic [LW-1:0]  q1_base;
   logic [TW-1:0]  q1_dead;
   logic           e_valid_ff, e_held_ff, e_zero_ff, e_zero_in;
   logic [LW-1:0]  e_on_ff, e_on_in;
   logic [KB-1:0]  e_rr_ff, e_rr_in;
   logic [DXW-1:0] dead_x;

   assign {q1_held, q1_sub, q1_base, q1_dead} = q1_side;

   always_comb begin
      e_on_in   = q1_sub ? q1_base - q1_quot : q1_base + q1_quot;
      dead_x    = DXW'(q1_dead);
      e_zero_in = (rel_ff == '0) || (dead_x >= DXW'(rel_ff));
      e_rr_in   = rel_ff - dead_x[KB-1:0];
   end

   // multiply into release divider
   logic           f_valid_ff;
   logic [NW-1:0]  f_num_ff, f_num_in;
   logic [KB-1:0]  f_den_ff, f_den_in;
   logic [SW2-1:0] f_side_ff;

   always_comb begin
      if (e_held_ff || e_zero_ff) begin
         f_num_in = '0;
         f_den_in = KB'(1);
      end else begin
         f_num_in = NW'(e_on_ff) * NW'(e_rr_ff);
         f_den_in = rel_ff;
      end
   end

   logic           q2_valid;
   logic [LW-1:0]  q2_quot;
   logic [SW2-1:0] q2_side;

   adsr_div #(.QW(LW), .DW(KB), .SW(SW2)) u_div_release (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (f_valid_ff),
      .in_num    (f_num_ff),
      .in_den    (f_den_ff),
      .in_side   (f_side_ff),
      .out_valid (q2_valid),
      .out_quot  (q2_quot),
      .out_side  (q2_side)
   );

   // final level and epsilon clamp
   logic          q2_held, q2_zero;
   logic [LW-1:0] q2_on, lvl, lvl_c;
   logic [OW-1:0] lvl_x;
   logic          o_valid_ff;
   rsp_type       o_data_ff, o_data_in;

   assign {q2_held, q2_zero, q2_on} = q2_side;

   always_comb begin
      if (q2_held) begin
         lvl = q2_on;
      end else if (q2_zero) begin
         lvl = '0;
      end else begin
         lvl = q2_quot;
      end
      lvl_c            = (lvl < LW'(EPS)) ? '0 : lvl;
      lvl_x            = OW'(lvl_c);
      o_data_in.level  = lvl_x[LVL_BITS-1:0];
      o_data_in.silent = lvl_c == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= q1_valid;
         f_valid_ff <= e_valid_ff;
         o_valid_ff <= q2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_now_ff   <= now_x[TW-1:0];
         a_press_ff <= press_x[TW-1:0];
         a_lift_ff  <= lift_x[TW-1:0];
         b_held_ff  <= b_held_in;
         b_life_ff  <= b_life_in;
         b_dead_ff  <= b_dead_in;
         c_held_ff  <= b_held_ff;
         c_dead_ff  <= b_dead_ff;
         c_sub_ff   <= c_sub_in;
         c_ma_ff    <= c_ma_in;
         c_mb_ff    <= c_mb_in;
         c_den_ff   <= c_den_in;
         c_base_ff  <= c_base_in;
         d_num_ff   <= NW'(c_ma_ff) * NW'(c_mb_ff);
         d_den_ff   <= c_den_ff;
         d_side_ff  <= {c_held_ff, c_sub_ff, c_base_ff, c_dead_ff};
         e_held_ff  <= q1_held;
         e_zero_ff  <= e_zero_in;
         e_on_ff    <= e_on_in;
         e_rr_ff    <= e_rr_in;
         f_num_ff   <= f_num_in;
         f_den_ff   <= f_den_in;
         f_side_ff  <= {e_held_ff, e_zero_ff, e_on_ff};
         o_data_ff  <= o_data_in;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_data_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> c_den_ff != '0)
      else $error("ramp divisor is zero");

   a_on_full: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> e_on_ff <= FULL)
      else $error("level at lift above full scale");

   a_rel_den: assert property (@(posedge clock) disable iff (reset)
      f_valid_ff |-> f_den_ff != '0)
      else $error("release divisor is zero");

endmodule
